/* src/dq_pkg.sv */
// Package for the double-ended queue core: sizes, opcodes, error codes,
// controller state type and the controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps

package dq_pkg;

   // DEPTH must be a power of two: ring indexes wrap by truncation
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // fixed field widths of the stream words
   localparam int OP_W   = 3;
   localparam int DIN_W  = 32;
   localparam int DOUT_W = 32;
   localparam int ERR_W  = 2;
   localparam int LEN_W  = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;

   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load;    // take the request word, start the slot read
      logic commit;  // update pointers, write slot, load response register
   } cmd_type;

   typedef struct packed {
      logic out_free; // response register empty or being drained this cycle
   } status_type;

endpackage

/* src/dq_ctrl.sv */
// Controller for the double-ended queue core: two-state sequencer that
// loads a request word and commits it once the response register is free.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  dq_pkg::status_type status,
   output dq_pkg::cmd_type    cmd
);
   import dq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_EXEC: begin
            cmd.commit = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_commit_in_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> state_ff == ST_EXEC)
      else $error("commit issued outside the execute state");
   a_load_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_EXEC)
      else $error("loaded word did not move to execute");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.commit))
      else $error("load and commit in the same cycle");
`endif

endmodule

/* src/dq_datapath.sv */
// Datapath for the double-ended queue core: slot memory, head and occupancy
// registers, operation decode and the response register.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  dq_pkg::cmd_type             cmd,
   output dq_pkg::status_type          status,
   input  logic [dq_pkg::OP_W-1:0]     opcode,
   input  logic [dq_pkg::DIN_W-1:0]    data_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dq_pkg::DOUT_W-1:0]   data_out,
   output logic [dq_pkg::ERR_W-1:0]    error,
   output logic [dq_pkg::LEN_W-1:0]    length,
   output logic                        empty_res,
   output logic                        full_res
);
   import dq_pkg::*;

   logic [DATA_WIDTH-1:0] slots [DEPTH];

   logic [OP_W-1:0]       op_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic                  rsp_valid_ff;
   logic [DOUT_W-1:0]     data_out_ff, data_out_in;
   logic [ERR_W-1:0]      error_ff, error_in;
   logic [LEN_W-1:0]      length_ff;
   logic                  empty_ff, full_ff;

   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   logic                  wr_en;
   logic                  is_empty, is_full;

   assign is_empty = (occ_ff == '0);
   assign is_full  = (occ_ff == CNT_W'(DEPTH));

   // read address from the pointers as they stand when the word is taken
   always_comb begin
      if (opcode == OP_POP_REAR) begin
         rd_addr = head_ff + occ_ff[IDX_W-1:0] - IDX_W'(1);
      end else begin
         rd_addr = head_ff;
      end
   end

   always_comb begin
      head_in     = head_ff;
      occ_in      = occ_ff;
      data_out_in = '0;
      error_in    = ERR_NONE;
      wr_en       = 1'b0;
      wr_addr     = head_ff + occ_ff[IDX_W-1:0];
      case (op_ff)
         OP_PUSH_REAR: begin
            if (is_full) begin
               error_in = ERR_FULL;
            end else begin
               wr_en  = 1'b1;
               occ_in = occ_ff + CNT_W'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (is_full) begin
               error_in = ERR_FULL;
            end else begin
               wr_en   = 1'b1;
               wr_addr = head_ff - IDX_W'(1);
               head_in = head_ff - IDX_W'(1);
               occ_in  = occ_ff + CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               error_in = ERR_EMPTY;
            end else begin
               data_out_in = DOUT_W'(rd_data_ff);
               head_in     = head_ff + IDX_W'(1);
               occ_in      = occ_ff - CNT_W'(1);
            end
         end
         OP_POP_REAR: begin
            if (is_empty) begin
               error_in = ERR_EMPTY;
            end else begin
               data_out_in = DOUT_W'(rd_data_ff);
               occ_in      = occ_ff - CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            head_in = '0;
            occ_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= opcode;
         word_ff    <= DATA_WIDTH'(data_in);
         rd_data_ff <= slots[rd_addr];
      end
      if (cmd.commit && wr_en) begin
         slots[wr_addr] <= word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            head_ff      <= head_in;
            occ_ff       <= occ_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         data_out_ff <= data_out_in;
         error_ff    <= error_in;
         length_ff   <= LEN_W'(occ_in);
         empty_ff    <= (occ_in == '0);
         full_ff     <= (occ_in == CNT_W'(DEPTH));
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign data_out  = data_out_ff;
   assign error     = error_ff;
   assign length    = length_ff;
   assign empty_res = empty_ff;
   assign full_res  = full_ff;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond capacity");
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed word not presented");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && op_ff == OP_CLEAR |=> occ_ff == '0 && head_ff == '0)
      else $error("clear left pointers set");
   a_len_match: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> length_ff == LEN_W'(occ_ff) && empty_ff == (occ_ff == '0))
      else $error("reported status differs from occupancy");
`endif

endmodule

/* src/double_ended_queue_core.sv */
// A request is taken in the idle state with a registered slot-memory read; the commit in the
// execute state waits for a free response register, then returns to idle for the next request.
// A waiting response does not block the next request from being taken.
// Reset (synchronous): queue empty, head at slot 0, no response pending.
// Slot contents are not cleared; a pop only ever reaches written slots.
// Top level of the double-ended queue core; depends on dq_pkg, dq_ctrl and dq_datapath.
`timescale 1ns / 1ps

module double_ended_queue_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dq_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [31:0] data_in
   input  logic [dq_pkg::OP_W-1:0]          req_tuser,  // [2:0] opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [31:0] data_out, [36:32] length,
                                                        // [37] empty_res, [38] full_res
   output logic [dq_pkg::ERR_W-1:0]         rsp_tuser   // [1:0] error
);
   import dq_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [DOUT_W-1:0] data_out;
   logic [LEN_W-1:0]  length;
   logic              empty_res;
   logic              full_res;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .opcode    (req_tuser),
      .data_in   (req_tdata[DIN_W-1:0]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .data_out  (data_out),
      .error     (rsp_tuser),
      .length    (length),
      .empty_res (empty_res),
      .full_res  (full_res)
   );

   assign rsp_tdata = {1'b0, full_res, empty_res, length, data_out};

endmodule
